[design/illm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the indexed linked list manager.
// Depends on nothing; imported by the controller, the datapath and the top level.
package illm_pkg;

  localparam int unsigned MaxItems = 256;
  localparam int unsigned ItemW    = 9;
  localparam int unsigned IdxW     = $clog2(MaxItems);
  localparam int unsigned CntW     = ItemW;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_APPEND     = 3'd1,
    MODE_GET_NTH    = 3'd2,
    MODE_TRUNCATE   = 3'd3,
    MODE_SUCCESSOR  = 3'd4,
    MODE_MEMBER     = 3'd5,
    MODE_TAIL       = 3'd6,
    MODE_CLEAR      = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_LISTED     = 2'd1,
    ST_NOT_LISTED = 2'd2,
    ST_RANGE      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_PUSH,
    MEM_APPEND,
    MEM_LINK,
    MEM_RD_OPND,
    MEM_RD_HEAD,
    MEM_RD_CUR
  } mem_op_e;

  typedef enum logic [2:0] {
    WALK_NONE,
    WALK_INIT_GET,
    WALK_INIT_TRUNC,
    WALK_STEP_CUR,
    WALK_STEP_HEAD
  } walk_op_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_RDATA,
    RES_CUR,
    RES_TAIL
  } res_src_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_APPEND_FIN,
    S_SUCC_WAIT,
    S_GET_CHK,
    S_GET_WAIT,
    S_TRUNC_CHK,
    S_TRUNC_WAIT,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]       mode;
    logic [ItemW-1:0] operand_value;
  } req_t;

  typedef struct packed {
    logic [ItemW-1:0] result_item;
    logic             is_member;
    logic [1:0]       status;
  } rsp_t;

  typedef struct packed {
    logic     ld_in;
    mem_op_e  mem_op;
    walk_op_e walk_op;
    logic     clear_all;
    logic     res_ld;
    res_src_e res_src;
    logic     res_mem;
    status_e  res_st;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  in_range;
    logic  listed;
    logic  head_zero;
    logic  cur_zero;
    logic  cnt_done;
  } dp_status_t;

  function automatic logic [IdxW-1:0] item_idx(logic [ItemW-1:0] item);
    logic [ItemW-1:0] dec;
    dec = item - ItemW'(1);
    return dec[IdxW-1:0];
  endfunction

endpackage

[design/illm_ctrl.sv]
`timescale 1ns / 1ps
// Controller FSM: sequences each transaction and drives datapath commands.
// Depends on illm_pkg.
module illm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  illm_pkg::dp_status_t   dp_status_i,
  output illm_pkg::cmd_t         cmd_o
);
  import illm_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        walk_end_get, walk_end_trunc;

  assign walk_end_get   = dp_status_i.cnt_done || dp_status_i.cur_zero;
  assign walk_end_trunc = dp_status_i.cnt_done || dp_status_i.head_zero;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (dp_status_i.mode) inside
          MODE_APPEND: begin
            if (dp_status_i.in_range && !dp_status_i.listed && !dp_status_i.head_zero) begin
              state_d = S_APPEND_FIN;
            end
          end
          MODE_GET_NTH: begin
            if (dp_status_i.in_range) state_d = S_GET_CHK;
          end
          MODE_TRUNCATE: state_d = S_TRUNC_CHK;
          MODE_SUCCESSOR: begin
            if (dp_status_i.in_range && dp_status_i.listed) state_d = S_SUCC_WAIT;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_APPEND_FIN: state_d = S_DONE;
      S_SUCC_WAIT:  state_d = S_DONE;
      S_GET_CHK:    state_d = walk_end_get ? S_DONE : S_GET_WAIT;
      S_GET_WAIT:   state_d = S_GET_CHK;
      S_TRUNC_CHK:  state_d = walk_end_trunc ? S_DONE : S_TRUNC_WAIT;
      S_TRUNC_WAIT: state_d = S_TRUNC_CHK;
      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: cmd_o.ld_in = in_valid_i;
      S_EXEC: begin
        unique case (dp_status_i.mode) inside
          MODE_PUSH_FRONT, MODE_APPEND: begin
            cmd_o.res_ld = 1'b1;
            if (!dp_status_i.in_range) begin
              cmd_o.res_st = ST_RANGE;
            end else if (dp_status_i.listed) begin
              cmd_o.res_mem = 1'b1;
              cmd_o.res_st  = ST_LISTED;
            end else begin
              cmd_o.res_mem = 1'b1;
              if (dp_status_i.mode == MODE_PUSH_FRONT) begin
                cmd_o.mem_op = MEM_PUSH;
              end else if (dp_status_i.head_zero) begin
                cmd_o.mem_op = MEM_APPEND;
              end else begin
                cmd_o.mem_op = MEM_LINK;
              end
            end
          end
          MODE_GET_NTH: begin
            if (dp_status_i.in_range) begin
              cmd_o.walk_op = WALK_INIT_GET;
            end else begin
              cmd_o.res_ld = 1'b1;
            end
          end
          MODE_TRUNCATE: begin
            cmd_o.walk_op = WALK_INIT_TRUNC;
            cmd_o.res_ld  = 1'b1;
          end
          MODE_SUCCESSOR: begin
            if (!dp_status_i.in_range) begin
              cmd_o.res_ld = 1'b1;
              cmd_o.res_st = ST_RANGE;
            end else if (!dp_status_i.listed) begin
              cmd_o.res_ld = 1'b1;
              cmd_o.res_st = ST_NOT_LISTED;
            end else begin
              cmd_o.mem_op = MEM_RD_OPND;
            end
          end
          MODE_MEMBER: begin
            cmd_o.res_ld = 1'b1;
            if (!dp_status_i.in_range) begin
              cmd_o.res_st = ST_RANGE;
            end else begin
              cmd_o.res_mem = dp_status_i.listed;
            end
          end
          MODE_TAIL: begin
            cmd_o.res_ld  = 1'b1;
            cmd_o.res_src = RES_TAIL;
          end
          default: begin
            cmd_o.clear_all = 1'b1;
            cmd_o.res_ld    = 1'b1;
          end
        endcase
      end
      S_APPEND_FIN: cmd_o.mem_op = MEM_APPEND;
      S_SUCC_WAIT: begin
        cmd_o.res_ld  = 1'b1;
        cmd_o.res_src = RES_RDATA;
        cmd_o.res_mem = 1'b1;
      end
      S_GET_CHK: begin
        if (walk_end_get) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_src = RES_CUR;
        end else begin
          cmd_o.mem_op = MEM_RD_CUR;
        end
      end
      S_GET_WAIT: cmd_o.walk_op = WALK_STEP_CUR;
      S_TRUNC_CHK: begin
        if (!walk_end_trunc) cmd_o.mem_op = MEM_RD_HEAD;
      end
      S_TRUNC_WAIT: cmd_o.walk_op = WALK_STEP_HEAD;
      S_DONE: cmd_o.out_ld = !out_valid_q || out_ready_i;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_EXEC)
    else $error("accepted transaction did not start execution");

  a_valid_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result valid raised outside completion");

  a_done_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !out_valid_q |=> state_q == S_IDLE && out_valid_q)
    else $error("result not delivered into a free output slot");

endmodule

[design/illm_datapath.sv]
`timescale 1ns / 1ps
// Datapath: successor memory, listed flags, head/tail, walk registers, result regs.
// Depends on illm_pkg; driven by illm_ctrl commands.
module illm_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  illm_pkg::req_t        in_data_i,
  input  illm_pkg::cmd_t        cmd_i,
  output illm_pkg::dp_status_t  dp_status_o,
  output illm_pkg::rsp_t        out_data_o
);
  import illm_pkg::*;

  logic [ItemW-1:0]    succ_mem [MaxItems];
  logic [ItemW-1:0]    rdata_q;

  logic [2:0]          mode_q;
  logic [ItemW-1:0]    opnd_q;
  logic [ItemW-1:0]    head_q, head_d;
  logic [ItemW-1:0]    tail_q, tail_d;
  logic [MaxItems-1:0] flags_q, flags_d;
  logic [ItemW-1:0]    cur_q, cur_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  rsp_t                pend_q, out_q;

  logic                wr_en, rd_en;
  logic [IdxW-1:0]     wr_addr, rd_addr;
  logic [ItemW-1:0]    wr_data;
  logic [IdxW-1:0]     opnd_idx, head_idx;

  assign opnd_idx = item_idx(opnd_q);
  assign head_idx = item_idx(head_q);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = opnd_idx;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = opnd_idx;
    unique case (cmd_i.mem_op)
      MEM_PUSH: begin
        wr_en   = 1'b1;
        wr_data = head_q;
      end
      MEM_APPEND: wr_en = 1'b1;
      MEM_LINK: begin
        wr_en   = 1'b1;
        wr_addr = item_idx(tail_q);
        wr_data = opnd_q;
      end
      MEM_RD_OPND: rd_en = 1'b1;
      MEM_RD_HEAD: begin
        rd_en   = 1'b1;
        rd_addr = head_idx;
      end
      MEM_RD_CUR: begin
        rd_en   = 1'b1;
        rd_addr = item_idx(cur_q);
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) succ_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= succ_mem[rd_addr];
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    flags_d = flags_q;
    if (cmd_i.clear_all) begin
      head_d  = '0;
      tail_d  = '0;
      flags_d = '0;
    end
    case (cmd_i.mem_op)
      MEM_PUSH: begin
        head_d            = opnd_q;
        flags_d[opnd_idx] = 1'b1;
        if (head_q == '0) tail_d = opnd_q;
      end
      MEM_APPEND: begin
        tail_d            = opnd_q;
        flags_d[opnd_idx] = 1'b1;
        if (head_q == '0) head_d = opnd_q;
      end
      MEM_RD_HEAD: flags_d[head_idx] = 1'b0;
      default: ;
    endcase
    if (cmd_i.walk_op == WALK_STEP_HEAD) begin
      head_d = rdata_q;
      if (rdata_q == '0) tail_d = '0;
    end
  end

  always_comb begin
    cur_d = cur_q;
    cnt_d = cnt_q;
    case (cmd_i.walk_op)
      WALK_INIT_GET: begin
        cur_d = head_q;
        cnt_d = CntW'(1);
      end
      WALK_INIT_TRUNC: cnt_d = '0;
      WALK_STEP_CUR: begin
        cur_d = rdata_q;
        cnt_d = cnt_q + CntW'(1);
      end
      WALK_STEP_HEAD: cnt_d = cnt_q + CntW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      flags_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    cnt_q <= cnt_d;
    if (cmd_i.ld_in) begin
      mode_q <= in_data_i.mode;
      opnd_q <= in_data_i.operand_value;
    end
    if (cmd_i.res_ld) begin
      case (cmd_i.res_src)
        RES_RDATA: pend_q.result_item <= rdata_q;
        RES_CUR:   pend_q.result_item <= cur_q;
        RES_TAIL:  pend_q.result_item <= tail_q;
        default:   pend_q.result_item <= '0;
      endcase
      pend_q.is_member <= cmd_i.res_mem;
      pend_q.status    <= cmd_i.res_st;
    end
    if (cmd_i.out_ld) out_q <= pend_q;
  end

  assign dp_status_o.mode      = mode_e'(mode_q);
  assign dp_status_o.in_range  = (opnd_q != '0) && (opnd_q <= ItemW'(MaxItems));
  assign dp_status_o.listed    = flags_q[opnd_idx];
  assign dp_status_o.head_zero = (head_q == '0);
  assign dp_status_o.cur_zero  = (cur_q == '0);
  assign dp_status_o.cnt_done  = (cnt_q >= opnd_q);

  assign out_data_o = out_q;

  a_head_tail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == '0) == (tail_q == '0))
    else $error("head and tail disagree on empty list");

  a_step_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_op == WALK_STEP_HEAD || cmd_i.walk_op == WALK_STEP_CUR |->
      $past(cmd_i.mem_op == MEM_RD_HEAD || cmd_i.mem_op == MEM_RD_CUR))
    else $error("walk step without a preceding successor read");

  a_no_read_of_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_op == MEM_RD_CUR |-> cur_q != '0)
    else $error("successor read of item none");

endmodule

[design/indexed_linked_list_manager_core.sv]
`timescale 1ns / 1ps
// Indexed linked list manager: ordered list of distinct items 1..256 kept in a
// successor memory with head/tail registers and per-item listed flags.
// Usage:
//   Input channel in_valid_i/in_ready_o carries one request transaction
//   (mode, operand_value); output channel out_valid_o/out_ready_i returns
//   exactly one response transaction (result_item, is_member, status) per request.
//   One request is in flight at a time. From acceptance, push_front, member, tail,
//   clear, get_nth at position 0 or above 256, and errors go from execution
//   straight to completion; append to a non-empty list adds a finishing state
//   and successor a wait for the read; other get_nth and truncate walk links
//   through their check and wait states. The block returns to idle as the
//   response is registered and takes the next request from there.
//   Each walked link takes a read and then a step, since the successor
//   memory returns registered read data.
//   The response sits in an output register; a new request is accepted while it
//   waits. A stalled receiver holds the finished result of the following
//   request inside the block and keeps in_ready_o low until the slot frees.
//   Reset empties the list at once (flags in flip-flops); the successor memory
//   is not cleared and needs no clearing pass.
module indexed_linked_list_manager_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  illm_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output illm_pkg::rsp_t out_data_o
);
  import illm_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_status;

  illm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  illm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .dp_status_o (dp_status),
    .out_data_o  (out_data_o)
  );

endmodule
